// ===== src/aes256_ctr_stream_cipher_core_assert.svh =====
// assertion macros shared by the cipher modules
`ifndef AES256_CTR_STREAM_CIPHER_CORE_ASSERT_SVH
`define AES256_CTR_STREAM_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define A256C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define A256C_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/a256c_pkg.sv =====
// types, tables and round functions for the aes-256 ctr cipher
`default_nettype none
package a256c_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

  localparam logic [3:0] LAST_ROUND = 4'd14;
  localparam logic [3:0] LAST_POS   = 4'd15;

  typedef struct packed {
    logic       enc;
    logic [7:0] data;
    logic       last;
  } q_item_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // last entry never used by aes-256
  localparam logic [7:0] RCON [0:7] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // subbytes, shiftrows and (unless final) mixcolumns; byte 0 in the top bits
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic fin);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[127-8*(4*((c+r)&3)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    return o;
  endfunction

  // next eight words of the aes-256 key schedule
  function automatic logic [255:0] next_window(input logic [255:0] w, input logic [7:0] rc);
    logic [31:0] n [8];
    logic [31:0] t;
    t = w[31:0];
    n[0] = w[255:224] ^ {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
    n[1] = w[223:192] ^ n[0];
    n[2] = w[191:160] ^ n[1];
    n[3] = w[159:128] ^ n[2];
    n[4] = w[127:96]  ^ sub_word(n[3]);
    n[5] = w[95:64]   ^ n[4];
    n[6] = w[63:32]   ^ n[5];
    n[7] = w[31:0]    ^ n[6];
    return {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
  endfunction

endpackage
`default_nettype wire

// ===== src/a256c_front.sv =====
// input side: two-entry queue of tagged bytes
`default_nettype none
module a256c_front import a256c_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_in,
  input  wire logic       enable,
  output logic            head_valid,
  output q_item_t         head_item,
  input  wire logic       head_pop
);

  q_item_t    ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !head_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && head_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (head_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // byte tagged with the mode it was taken in
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{enc: enable, data: in_data_byte, last: in_last_in};
    end
  end

`include "aes256_ctr_stream_cipher_core_assert.svh"
  `A256C_ASSERT_IMP(a_pop_nonempty, head_pop, cnt_r != 2'd0, "pop from empty queue")
  `A256C_ASSERT_IMP(a_ptr_track, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r, "queue pointers out of step")

endmodule
`default_nettype wire

// ===== src/a256c_aes.sv =====
// iterative aes-256 engine, one round per cycle, key schedule on the fly
`default_nettype none
module a256c_aes import a256c_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         flush,
  input  wire logic         start,
  input  wire logic [127:0] blk_in,
  input  wire logic [255:0] key,
  output logic              busy,
  output logic              done,
  output logic [127:0]      blk_out
);

  logic         busy_r, done_r;
  logic [3:0]   round_r;
  logic [127:0] state_r;
  logic [255:0] win_r;
  logic [127:0] rkey;
  logic         fin;

  assign busy    = busy_r;
  assign done    = done_r;
  assign blk_out = state_r;
  // odd rounds take the lower half of the window
  assign rkey    = round_r[0] ? win_r[127:0] : win_r[255:128];
  assign fin     = (round_r == LAST_ROUND);

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        round_r <= 4'd1;
      end else if (busy_r) begin
        round_r <= round_r + 4'd1;
        if (fin) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          round_r <= 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      state_r <= blk_in ^ key[255:128];
      win_r   <= key;
    end else if (busy_r) begin
      state_r <= enc_round(state_r, fin) ^ rkey;
      if (round_r[0]) begin
        win_r <= next_window(win_r, RCON[round_r[3:1]]);
      end
    end
  end

`include "aes256_ctr_stream_cipher_core_assert.svh"
  `A256C_ASSERT_IMP(a_round_range, busy_r, round_r != 4'd0 && round_r <= LAST_ROUND, "round out of range")
  `A256C_ASSERT_NXT(a_done_after_last, busy_r && fin && !flush, done_r && !busy_r, "no done after last round")

endmodule
`default_nettype wire

// ===== src/a256c_back.sv =====
// back side: keystream double buffer, counter, xor and output register
`default_nettype none
module a256c_back import a256c_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         key_load,
  input  wire logic [255:0] key,
  input  wire logic         head_valid,
  input  q_item_t           head_item,
  output logic              head_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_result_byte,
  output logic              out_last_out
);

  logic [127:0] cur_r, nxt_r;
  logic         cur_v_r, nxt_v_r, cur_v_nxt, nxt_v_nxt;
  logic [3:0]   pos_r;
  logic [31:0]  gen_ctr_r;
  logic         out_v_r;
  logic [7:0]   res_r;
  logic         last_r;
  logic         fire, pop_blk, start, eng_busy, eng_done;
  logic [127:0] eng_blk;
  logic [7:0]   ks_byte;

  assign fire     = head_valid && (!out_v_r || !out_stall) && (!head_item.enc || cur_v_r);
  assign pop_blk  = fire && head_item.enc && (pos_r == LAST_POS);
  assign head_pop = fire;
  assign start    = !eng_busy && !eng_done && (!nxt_v_r || pop_blk) && !key_load;
  assign ks_byte  = cur_r[{~pos_r, 3'b000} +: 8];

  assign out_valid       = out_v_r;
  assign out_result_byte = res_r;
  assign out_last_out    = last_r;

  // counter block is nonce then big-endian counter
  a256c_aes u_aes (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (key_load),
    .start   (start),
    .blk_in  ({key[255:160], gen_ctr_r}),
    .key     (key),
    .busy    (eng_busy),
    .done    (eng_done),
    .blk_out (eng_blk)
  );

  always_comb begin
    cur_v_nxt = cur_v_r;
    nxt_v_nxt = nxt_v_r;
    if (pop_blk) begin
      cur_v_nxt = nxt_v_r;
      nxt_v_nxt = 1'b0;
    end
    if (eng_done) begin
      if (cur_v_nxt) begin
        nxt_v_nxt = 1'b1;
      end else begin
        cur_v_nxt = 1'b1;
      end
    end
    if (key_load) begin
      cur_v_nxt = 1'b0;
      nxt_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r   <= 1'b0;
      nxt_v_r   <= 1'b0;
      pos_r     <= 4'd0;
      gen_ctr_r <= 32'd0;
      out_v_r   <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      nxt_v_r <= nxt_v_nxt;
      if (key_load) begin
        pos_r     <= 4'd0;
        gen_ctr_r <= 32'd0;
      end else begin
        if (fire && head_item.enc) begin
          pos_r <= pos_r + 4'd1;
        end
        if (start) begin
          gen_ctr_r <= gen_ctr_r + 32'd1;
        end
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_blk) begin
      cur_r <= nxt_r;
    end
    if (eng_done) begin
      if (cur_v_nxt && !(pop_blk ? 1'b0 : !cur_v_r)) begin
        if (pop_blk && !nxt_v_r) begin
          cur_r <= eng_blk;
        end else if (pop_blk || cur_v_r) begin
          nxt_r <= eng_blk;
        end else begin
          cur_r <= eng_blk;
        end
      end else begin
        cur_r <= eng_blk;
      end
    end
    if (fire) begin
      res_r  <= head_item.data ^ (head_item.enc ? ks_byte : 8'h00);
      last_r <= head_item.last;
    end
  end

`include "aes256_ctr_stream_cipher_core_assert.svh"
  `A256C_ASSERT_IMP(a_no_done_when_full, eng_done, !nxt_v_r || pop_blk, "keystream block with no free slot")
  `A256C_ASSERT_IMP(a_order, nxt_v_r, cur_v_r, "next block held without current")
  `A256C_ASSERT_NXT(a_pos_wrap, pop_blk && !key_load, pos_r == 4'd0, "position did not wrap")

endmodule
`default_nettype wire

// ===== src/aes256_ctr_stream_cipher_core.sv =====
// top level of the aes-256 counter-mode byte stream cipher
//
// channels: in_ (data_byte, last_in) and out_ (result_byte, last_out) move one
// byte per beat with valid/stall; a beat moves when valid is high and stall low.
// cfg_ writes a register (0..3 key words, 4 enable) when cfg_valid is high;
// cfg_ready is always high. a key write restarts counter and byte position.
// path: a byte is written into a two-entry queue, then from the queue head
// into the output register, from which it leaves.
// throughput: one byte per cycle in steady state when nothing stalls. a
// keystream block is made in the iterative round unit (load, 14 rounds,
// hand-over) while the previous 16 bytes go out, so bytes keep flowing.
// after a key write the first enabled byte waits for block 0.
// disabled bytes pass straight through and do not need a keystream block.
// reset: counter, position, buffers and queue clear; key and enable read 0.
// a stalled output holds its beat; the queue fills and in_stall then rises,
// while the round unit finishes the block it is on and waits.
`default_nettype none
module aes256_ctr_stream_cipher_core import a256c_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_last_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_result_byte,
  output logic                      out_last_out,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] key_r [4];
  logic        enable_r;
  logic        key_load;
  logic        head_valid, head_pop;
  q_item_t     head_item;

  assign cfg_ready = 1'b1;

  // any key word write restarts the stream
  always_comb begin
    key_load = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_load = 1'b1;
        default:                                key_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= 64'd0;
      key_r[1] <= 64'd0;
      key_r[2] <= 64'd0;
      key_r[3] <= 64'd0;
      enable_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY0:   key_r[0] <= cfg_data;
        REG_KEY1:   key_r[1] <= cfg_data;
        REG_KEY2:   key_r[2] <= cfg_data;
        REG_KEY3:   key_r[3] <= cfg_data;
        REG_ENABLE: enable_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // front: queue of bytes tagged with the mode
  a256c_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_in   (in_last_in),
    .enable       (enable_r),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_pop     (head_pop)
  );

  // back: keystream generation and xor
  a256c_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_load        (key_load),
    .key             ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .head_pop        (head_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte),
    .out_last_out    (out_last_out)
  );

endmodule
`default_nettype wire

// ===== test/aes_ctr_keystream_check.sv =====
// checker for the aes-256 ctr byte cipher: predicts each output beat and compares
module aes_ctr_keystream_check import a256c_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_result_byte,
  input  logic                 out_last_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   pending,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_out;
  } cipher_beat_t;

  localparam logic [7:0] SUB_BYTE [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0]  key_word [4];
  logic         enc_on;
  logic [31:0]  ctr_value;
  logic [3:0]   byte_pos;
  logic [7:0]   ks_bytes [16];
  cipher_beat_t expected_beats [$];
  int           fails;

  function automatic logic [7:0] gf_x2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub4(input logic [31:0] v);
    return {SUB_BYTE[v[31:24]], SUB_BYTE[v[23:16]], SUB_BYTE[v[15:8]], SUB_BYTE[v[7:0]]};
  endfunction

  // byte 0 of key and block in the top bits
  function automatic logic [127:0] aes256_encrypt_block(input logic [255:0] key,
                                                        input logic [127:0] blk);
    logic [31:0]  w [60];
    logic [31:0]  t;
    logic [7:0]   rc;
    logic [7:0]   s [16];
    logic [7:0]   u [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 8; i++) w[i] = key[255-32*i -: 32];
    rc = 8'h01;
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_x2(rc);
      end else if (i % 8 == 4) begin
        t = sub4(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) s[4*c+r] ^= w[c][31-8*r -: 8];
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) u[4*c+r] = SUB_BYTE[s[4*((c+r)%4)+r]];
      for (int c = 0; c < 4; c++) begin
        a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
        if (rnd == 14) begin
          s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
        end else begin
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gf_x2(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ gf_x2(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ gf_x2(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ gf_x2(a3 ^ a0);
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4*c+r] ^= w[4*rnd+c][31-8*r -: 8];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic cipher_beat_t encrypt_byte(input logic [7:0] d, input logic l);
    cipher_beat_t b;
    logic [127:0] ks;
    b.result_byte = d;
    b.last_out    = l;
    if (enc_on) begin
      if (byte_pos == 4'd0) begin
        ks = aes256_encrypt_block({key_word[0], key_word[1], key_word[2], key_word[3]},
                                  {key_word[0], key_word[1][63:32], ctr_value});
        for (int i = 0; i < 16; i++) ks_bytes[i] = ks[127-8*i -: 8];
      end
      b.result_byte = d ^ ks_bytes[byte_pos];
      byte_pos = byte_pos + 4'd1;
      if (byte_pos == 4'd0) ctr_value = ctr_value + 32'd1;
    end
    return b;
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) key_word[i] = '0;
    enc_on     = 1'b0;
    ctr_value  = '0;
    byte_pos   = '0;
    fails      = 0;
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    cipher_beat_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_word[cfg_index[1:0]] = cfg_data;
            ctr_value = '0;
            byte_pos  = '0;
          end
          REG_ENABLE: enc_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_beats.push_back(encrypt_byte(in_data_byte, in_last_in));
      if (out_valid && !out_stall) begin
        got.result_byte = out_result_byte;
        got.last_out    = out_last_out;
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: result_byte %02h last_out %0d",
                 got.result_byte, got.last_out);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          if (got.result_byte !== want.result_byte) begin
            $error("result_byte expected %02h actual %02h", want.result_byte, got.result_byte);
            fails++;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out expected %0d actual %0d", want.last_out, got.last_out);
            fails++;
          end
        end
      end
      pending    <= expected_beats.size();
      fail_count <= fails;
    end
  end
endmodule

// ===== test/aes256_ctr_stream_cipher_core_tb.sv =====
// testbench top for the aes-256 ctr byte cipher: stimulus, stall pattern and verdict
module aes256_ctr_stream_cipher_core_tb;
  import a256c_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int SETTLE       = 40;   // covers block 0 after a key write plus queue
  localparam int HOLD_CYCLES  = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = '0;
  logic                 in_last_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_result_byte;
  logic                 out_last_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  int pending;
  int fail_count;
  int cycles = 0;
  bit quiet = 1'b0;      // no gaps on either side while set
  bit hold_req = 1'b0;   // asks the sink to hold off for a long stretch

  aes256_ctr_stream_cipher_core dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data_byte, .in_last_in,
    .out_valid, .out_stall, .out_result_byte, .out_last_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  aes_ctr_keystream_check checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data_byte, .in_last_in,
    .out_valid, .out_stall, .out_result_byte, .out_last_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .pending, .fail_count
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog, reckoned well beyond the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly no gap, some short ones and the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side stall pattern, with one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        out_stall <= (n != 0);
        if (n == 0) @(posedge clk);
        else repeat (n) @(posedge clk);
      end
    end
  end

  // valid stays high after the beat unless a gap follows, so back-to-back beats
  // never see valid lowered and raised in one step
  task automatic send_byte(input logic [7:0] d, input logic l);
    int n;
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_in   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = pick_gap();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // cfg_valid left high for back-to-back writes; settle lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // block idle: every beat returned, plus slack for work in flight
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_key(input logic [255:0] k);
    write_reg(REG_KEY0, k[255:192]);
    write_reg(REG_KEY1, k[191:128]);
    write_reg(REG_KEY2, k[127:64]);
    write_reg(REG_KEY3, k[63:0]);
  endtask

  initial begin
    logic [255:0] k;
    logic [7:0]   d;
    int           sel;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through out of reset, extremes of both fields
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    settle();

    // counting key, write to a missing register, then a run across a block edge
    load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
    write_reg(REG_UNUSED, '1);
    write_reg(REG_ENABLE, 64'd1);
    settle();
    for (int i = 0; i < 18; i++) send_byte((i % 2) ? 8'hff : 8'h00, i == 15);
    settle();

    // enable write must leave position and counter alone; upper bits are masked
    write_reg(REG_ENABLE, 64'hffff_ffff_ffff_fffe);
    settle();
    send_byte(8'ha5, 1'b1);
    settle();
    write_reg(REG_ENABLE, 64'd1);
    settle();
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b1);
    settle();

    // all-ones key restarts the stream
    load_key('1);
    settle();

    // random phases: new keys, occasional pass-through, one gap-free, one hold-off
    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 5);
      k = {$urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
      if (sel == 0) k = '0;
      else if (sel == 1) k = '1;
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_KEY0 + CFG_IDX_W'($urandom_range(0, 3)), k[63:0]);
      else
        load_key(k);
      write_reg(REG_ENABLE, {$urandom(), $urandom()} | 64'(ph != 6));
      if (ph == 2) write_reg(REG_UNUSED, {$urandom(), $urandom()});
      settle();
      quiet = (ph == 3);
      if (ph == 5) hold_req = 1'b1;
      for (int i = 0; i < 225; i++) begin
        d = $urandom_range(0, 255);
        sel = $urandom_range(0, 19);
        if (sel == 0) d = 8'h00;
        else if (sel == 1) d = 8'hff;
        send_byte(d, $urandom_range(0, 7) == 0);
      end
      quiet = 1'b0;
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/a256c_pkg.sv
src/a256c_front.sv
src/a256c_aes.sv
src/a256c_back.sv
src/aes256_ctr_stream_cipher_core.sv
test/aes_ctr_keystream_check.sv
test/aes256_ctr_stream_cipher_core_tb.sv
